@@ sv/csmt_pkg.sv @@
`default_nettype none

package csmt_pkg;

    // block size is kept a power of two so a value splits into block and offset bits
    localparam int BLK_SHIFT   = 6;
    localparam int BLOCK_SIZE  = 1 << BLK_SHIFT;
    localparam int NUM_BLOCKS  = 64;
    localparam int COUNT_WIDTH = 16;

    localparam int UNIVERSE = BLOCK_SIZE * NUM_BLOCKS;
    localparam int BLK_W    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int ADDR_W   = BLK_W + BLK_SHIFT;
    localparam int DIST_W   = $clog2(BLOCK_SIZE + 1);

    localparam int VALUE_W = 12;
    localparam int MEX_W   = 13;
    localparam int ERR_W   = 2;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_ABSENT   = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_BFIRST,
        S_BSCAN,
        S_VFIRST,
        S_VSCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                   we;
        logic [ADDR_W-1:0]      addr;
        logic [COUNT_WIDTH-1:0] wdata;
    } cnt_req_t;

    typedef struct packed {
        logic              we;
        logic [BLK_W-1:0]  addr;
        logic [DIST_W-1:0] wdata;
    } dist_req_t;

endpackage

`default_nettype wire

@@ sv/csmt_store.sv @@
`default_nettype none

module csmt_store
    import csmt_pkg::*;
(
    input  wire logic                   clk,
    input  wire cnt_req_t               cnt_req,
    input  wire dist_req_t              dist_req,
    output logic [COUNT_WIDTH-1:0]      cnt_rd,
    output logic [DIST_W-1:0]           dist_rd
);

    logic [COUNT_WIDTH-1:0] cnt_mem  [UNIVERSE];
    logic [DIST_W-1:0]      dist_mem [NUM_BLOCKS];

    // read returns the old entry when the same address is written
    always_ff @(posedge clk)
    begin
        if (cnt_req.we)
        begin
            cnt_mem[cnt_req.addr] <= cnt_req.wdata;
        end
        cnt_rd <= cnt_mem[cnt_req.addr];
    end

    always_ff @(posedge clk)
    begin
        if (dist_req.we)
        begin
            dist_mem[dist_req.addr] <= dist_req.wdata;
        end
        dist_rd <= dist_mem[dist_req.addr];
    end

endmodule

`default_nettype wire

@@ sv/counted_set_mex_tracker_core.sv @@
// a request passes through look-up and update, a scan of the block distinct counts, a
// scan of the value counts in the first block that is not full, and the done state; a new
// request is taken only in the idle state, once the last result is loaded; the block count
// scan and the value count scan each read one memory entry per cycle
// the next request is taken while a result still waits on the output register
// reset: rst_n clears control at once, then a clearing pass writes zero to all
// UNIVERSE count entries with s_axis_tready low
`default_nettype none

module counted_set_mex_tracker_core
    import csmt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [11:0] value
    input  wire logic        s_axis_tuser,   // [0] command: 0 insert, 1 remove
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [12:0] mex, [14:13] error
);

    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      clr_reg, clr_next;
    logic [BLK_W-1:0]       chk_reg, chk_next;
    logic [BLK_SHIFT-1:0]   k_reg, k_next;
    logic                   cmd_reg, cmd_next;
    logic [ADDR_W-1:0]      val_reg, val_next;
    logic                   inr_reg, inr_next;
    err_t                   err_reg, err_next;
    logic [MEX_W-1:0]       mex_reg, mex_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [15:0]            m_tdata_reg, m_tdata_next;

    cnt_req_t               cnt_req;
    dist_req_t              dist_req;
    logic [COUNT_WIDTH-1:0] cnt_rd;
    logic [DIST_W-1:0]      dist_rd;

    logic [ADDR_W-1:0]      in_addr;
    logic                   in_range;

    csmt_store u_store (
        .clk      (clk),
        .cnt_req  (cnt_req),
        .dist_req (dist_req),
        .cnt_rd   (cnt_rd),
        .dist_rd  (dist_rd)
    );

    assign in_addr  = ADDR_W'(s_axis_tdata[VALUE_W-1:0]);
    assign in_range = 32'(s_axis_tdata[VALUE_W-1:0]) < UNIVERSE;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg     <= chk_next;
        k_reg       <= k_next;
        cmd_reg     <= cmd_next;
        val_reg     <= val_next;
        inr_reg     <= inr_next;
        err_reg     <= err_next;
        mex_reg     <= mex_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        chk_next      = chk_reg;
        k_next        = k_reg;
        cmd_next      = cmd_reg;
        val_next      = val_reg;
        inr_next      = inr_reg;
        err_next      = err_reg;
        mex_next      = mex_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        cnt_req       = '0;
        dist_req      = '0;

        if (m_tvalid_reg && m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_req.we    = 1'b1;
                cnt_req.addr  = clr_reg;
                dist_req.we   = (32'(clr_reg) < NUM_BLOCKS);
                dist_req.addr = clr_reg[BLK_W-1:0];
                clr_next      = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(UNIVERSE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cnt_req.addr  = in_addr;
                dist_req.addr = in_addr[ADDR_W-1:BLK_SHIFT];
                if (s_axis_tvalid)
                begin
                    cmd_next   = s_axis_tuser;
                    val_next   = in_addr;
                    inr_next   = in_range;
                    err_next   = ERR_NONE;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cnt_req.addr  = val_reg;
                dist_req.addr = val_reg[ADDR_W-1:BLK_SHIFT];
                if (inr_reg)
                begin
                    if (!cmd_reg)
                    begin
                        if (&cnt_rd)
                        begin
                            err_next = ERR_OVERFLOW;
                        end
                        else
                        begin
                            cnt_req.we     = 1'b1;
                            cnt_req.wdata  = cnt_rd + 1'b1;
                            dist_req.we    = (cnt_rd == '0);
                            dist_req.wdata = dist_rd + 1'b1;
                        end
                    end
                    else
                    begin
                        if (cnt_rd == '0)
                        begin
                            err_next = ERR_ABSENT;
                        end
                        else
                        begin
                            cnt_req.we     = 1'b1;
                            cnt_req.wdata  = cnt_rd - 1'b1;
                            dist_req.we    = (cnt_rd == COUNT_WIDTH'(1));
                            dist_req.wdata = dist_rd - 1'b1;
                        end
                    end
                end
                state_next = S_BFIRST;
            end
            S_BFIRST:
            begin
                dist_req.addr = '0;
                chk_next      = '0;
                state_next    = S_BSCAN;
            end
            S_BSCAN:
            begin
                // read of the next block is issued while this one is checked
                dist_req.addr = chk_reg + 1'b1;
                if (dist_rd != DIST_W'(BLOCK_SIZE))
                begin
                    state_next = S_VFIRST;
                end
                else if (chk_reg == BLK_W'(NUM_BLOCKS - 1))
                begin
                    mex_next   = MEX_W'(UNIVERSE);
                    state_next = S_DONE;
                end
                else
                begin
                    chk_next = chk_reg + 1'b1;
                end
            end
            S_VFIRST:
            begin
                cnt_req.addr = {chk_reg, {BLK_SHIFT{1'b0}}};
                k_next       = '0;
                state_next   = S_VSCAN;
            end
            S_VSCAN:
            begin
                cnt_req.addr = {chk_reg, k_reg + 1'b1};
                if (cnt_rd == '0)
                begin
                    mex_next   = MEX_W'({chk_reg, k_reg});
                    state_next = S_DONE;
                end
                else if (k_reg == BLK_SHIFT'(BLOCK_SIZE - 1))
                begin
                    mex_next   = MEX_W'(UNIVERSE);
                    state_next = S_DONE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, err_reg, mex_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // a block that is not full must hold a value with zero count
    a_nonfull_has_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VSCAN && k_reg == BLK_SHIFT'(BLOCK_SIZE - 1)) |-> cnt_rd == '0)
        else $error("non-full block scanned without a zero count");

    // distinct count update stays within the block size
    a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK && dist_req.we) |-> dist_req.wdata <= DIST_W'(BLOCK_SIZE))
        else $error("block distinct count out of range");

    // a finished result waits while the output register is still occupied
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && m_tvalid_reg && !m_axis_tready) |=> state_reg == S_DONE)
        else $error("result loaded over a pending one");

endmodule

`default_nettype wire

@@ tb/tb_counted_set_mex_tracker_core.sv @@
`default_nettype none

module tb_counted_set_mex_tracker_core;
    import csmt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam longint unsigned COUNT_LIMIT = (64'd1 << COUNT_WIDTH) - 64'd1;
    localparam int LATENCY     = NUM_BLOCKS + BLOCK_SIZE + 4;
    // covers the clearing pass after reset and the longest stall on either side
    localparam int STALL_LIMIT = 20000;
    localparam int PHASE_ITEMS = 620;

    typedef struct packed {
        logic [MEX_W-1:0] mex;
        err_t             err;
    } mex_reply_t;

    typedef struct packed {
        logic               cmd;
        logic [VALUE_W-1:0] value;
        logic               typed;
        logic [MEX_W-1:0]   mex;
        err_t               err;
    } opening_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    counted_set_mex_tracker_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [11:0] value
        .s_axis_tuser  (s_axis_tuser),   // [0] command: 0 insert, 1 remove
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [12:0] mex, [14:13] error
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow multiset
    int unsigned value_tally [UNIVERSE];
    int unsigned block_fill [NUM_BLOCKS];

    mex_reply_t pending_mex [$];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int mismatches    = 0;
    int stall_cycles  = 0;
    int n_requests    = 0;
    int n_results     = 0;
    int n_overflow    = 0;
    int n_absent      = 0;
    int n_full        = 0;
    int top_mex       = 0;

    opening_row_t opening_rows [17] = '{
        '{CMD_REMOVE, 12'd0,    1'b1, 13'd0, ERR_ABSENT},
        '{CMD_REMOVE, 12'd4095, 1'b1, 13'd0, ERR_ABSENT},
        '{CMD_INSERT, 12'd4095, 1'b1, 13'd0, ERR_NONE},
        '{CMD_INSERT, 12'd0,    1'b1, 13'd1, ERR_NONE},
        '{CMD_INSERT, 12'd1,    1'b1, 13'd2, ERR_NONE},
        '{CMD_INSERT, 12'd0,    1'b1, 13'd2, ERR_NONE},
        '{CMD_REMOVE, 12'd0,    1'b1, 13'd2, ERR_NONE},
        '{CMD_REMOVE, 12'd0,    1'b1, 13'd0, ERR_NONE},
        '{CMD_REMOVE, 12'd0,    1'b1, 13'd0, ERR_ABSENT},
        '{CMD_INSERT, 12'd2,    1'b0, 13'd0, ERR_NONE},
        '{CMD_INSERT, 12'd63,   1'b0, 13'd0, ERR_NONE},
        '{CMD_INSERT, 12'd64,   1'b0, 13'd0, ERR_NONE},
        '{CMD_INSERT, 12'hAAA,  1'b0, 13'd0, ERR_NONE},
        '{CMD_INSERT, 12'h555,  1'b0, 13'd0, ERR_NONE},
        '{CMD_REMOVE, 12'hAAA,  1'b0, 13'd0, ERR_NONE},
        '{CMD_REMOVE, 12'hAAA,  1'b0, 13'd0, ERR_NONE},
        '{CMD_INSERT, 12'd0,    1'b0, 13'd0, ERR_NONE}
    };

    function automatic int unsigned lowest_absent();
        int unsigned blk;
        int unsigned base;
        blk = 0;
        while (blk < NUM_BLOCKS && block_fill[blk] == BLOCK_SIZE)
            blk++;
        if (blk >= NUM_BLOCKS)
            return UNIVERSE;
        base = blk * BLOCK_SIZE;
        for (int k = 0; k < BLOCK_SIZE; k++)
        begin
            if (value_tally[base + k] == 0)
                return base + k;
        end
        return UNIVERSE;
    endfunction

    function automatic mex_reply_t step_multiset(input logic cmd, input logic [VALUE_W-1:0] val);
        mex_reply_t  reply;
        int unsigned v;
        int unsigned blk;
        v         = 32'(val);
        blk       = v / BLOCK_SIZE;
        reply.err = ERR_NONE;
        if (v < UNIVERSE)
        begin
            if (cmd == CMD_INSERT)
            begin
                if (value_tally[v] >= COUNT_LIMIT)
                    reply.err = ERR_OVERFLOW;
                else
                begin
                    if (value_tally[v] == 0)
                        block_fill[blk]++;
                    value_tally[v]++;
                end
            end
            else
            begin
                if (value_tally[v] == 0)
                    reply.err = ERR_ABSENT;
                else
                begin
                    value_tally[v]--;
                    if (value_tally[v] == 0)
                        block_fill[blk]--;
                end
            end
        end
        reply.mex = MEX_W'(lowest_absent());
        return reply;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic queue_expected(input mex_reply_t reply);
        pending_mex = {pending_mex, reply};
    endtask

    // one request per call; tvalid stays high into the next call unless a gap is drawn
    task automatic send_request(input logic cmd, input logic [VALUE_W-1:0] val);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(16 - VALUE_W){1'b0}}, val};
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        n_requests++;
    endtask

    task automatic issue_checked(input logic cmd, input logic [VALUE_W-1:0] val);
        send_request(cmd, val);
        queue_expected(step_multiset(cmd, val));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_mex.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(input int src_pct, input int sink_pct);
        int          pick;
        int unsigned m;
        int unsigned lo;
        int unsigned hi;
        logic        cmd;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (i == PHASE_ITEMS / 2)
                drain_results();
            cmd  = 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 50)
                issue_checked(cmd, VALUE_W'($urandom_range(UNIVERSE - 1)));
            else
            begin
                // work around the current hole so the mex keeps moving
                m  = lowest_absent();
                if (m >= UNIVERSE)
                    m = UNIVERSE - 1;
                lo = (m > 40) ? m - 40 : 0;
                hi = (m + 40 > UNIVERSE - 1) ? UNIVERSE - 1 : m + 40;
                issue_checked(cmd, VALUE_W'($urandom_range(hi, lo)));
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        mex_reply_t want;
        logic [MEX_W-1:0] got_mex;
        err_t got_err;
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_mex = m_axis_tdata[MEX_W-1:0];
            got_err = err_t'(m_axis_tdata[MEX_W +: ERR_W]);
            n_results++;
            if (got_err == ERR_OVERFLOW)
                n_overflow++;
            if (got_err == ERR_ABSENT)
                n_absent++;
            if (got_mex == MEX_W'(UNIVERSE))
                n_full++;
            if (int'(got_mex) > top_mex)
                top_mex = got_mex;
            if (pending_mex.size() == 0)
                report_mismatch($sformatf("result mex %0d error %0d with no request pending",
                                          got_mex, got_err));
            else
            begin
                want = pending_mex.pop_front();
                if (got_mex !== want.mex)
                    report_mismatch($sformatf("result %0d: mex %0d, expected %0d",
                                              n_results, got_mex, want.mex));
                if (got_err !== want.err)
                    report_mismatch($sformatf("result %0d: error %0d, expected %0d",
                                              n_results, got_err, want.err));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("counted_set_mex_tracker_core test failed");
                $finish;
            end
        end
    end

    initial
    begin
        mex_reply_t row_reply;
        for (int i = 0; i < UNIVERSE; i++)
            value_tally[i] = 0;
        for (int b = 0; b < NUM_BLOCKS; b++)
            block_fill[b] = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // opening table: extremes, both commands, refused removes
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        foreach (opening_rows[i])
        begin
            send_request(opening_rows[i].cmd, opening_rows[i].value);
            row_reply = step_multiset(opening_rows[i].cmd, opening_rows[i].value);
            if (opening_rows[i].typed)
            begin
                row_reply.mex = opening_rows[i].mex;
                row_reply.err = opening_rows[i].err;
            end
            queue_expected(row_reply);
        end

        // stack several copies of zero and take one back
        issue_checked(CMD_INSERT, '0);
        issue_checked(CMD_REMOVE, '0);
        issue_checked(CMD_INSERT, '0);
        issue_checked(CMD_INSERT, '0);

        // fill the first block from the top down so the scan has to skip a full block
        for (int v = BLOCK_SIZE - 1; v >= 0; v--)
        begin
            if (value_tally[v] == 0)
                issue_checked(CMD_INSERT, VALUE_W'(v));
        end
        issue_checked(CMD_REMOVE, VALUE_W'(BLOCK_SIZE - 1));
        issue_checked(CMD_INSERT, VALUE_W'(BLOCK_SIZE - 1));

        drain_results();
        random_phase(16, 78);
        drain_results();
        random_phase(78, 16);
        drain_results();
        random_phase(0, 0);

        drain_results();
        repeat (2 * LATENCY) @(posedge clk);

        $display("%0d requests, %0d results; %0d overflow and %0d absent-remove refusals",
                 n_requests, n_results, n_overflow, n_absent);
        $display("highest mex %0d, full-universe answers %0d", top_mex, n_full);
        if (mismatches == 0)
            $display("counted_set_mex_tracker_core test passed");
        else
            $display("counted_set_mex_tracker_core test failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
sv/csmt_pkg.sv
sv/csmt_store.sv
sv/counted_set_mex_tracker_core.sv
tb/tb_counted_set_mex_tracker_core.sv
